// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL module line_endpoint_extraction_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that an antecedent in one cycle implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent in one cycle implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lee_pkg.sv
// Package with the beat types and constants of the line endpoint extraction block.
package lee_pkg;

  localparam int COORD_BITS  = 16;
  localparam int THRESH_BITS = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(400);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_row;
    coord_t point_col;
    logic   last_point;
  } point_t;

  typedef struct packed {
    coord_t first_end_row;
    coord_t first_end_col;
    coord_t second_end_row;
    coord_t second_end_col;
    logic   column_mode_used;
  } result_t;

endpackage

// File: rtl/core/line_endpoint_extraction_top.sv
// Line endpoint extraction: tracks run extremes and emits two endpoints per run.
//
//   Port group  Direction  Beat contents
//   in_         input      one edge point (row, column, last flag)
//   out_        output     two line endpoints and the column mode flag
//   cfg_        input      span threshold write, no read-back
//
// One point is accepted per cycle; the extremes are updated at the accepting edge.
// After a run's last point, fin_r is set, then its endpoints load into the output register.
// The result stage is the output register, so points keep flowing while it waits.
// A point is stalled only while a finished run waits for an output register that is full.
// Reset (rst_n low, synchronous) clears the run state and loads the threshold with 400.
`include "assert_macros.svh"

module line_endpoint_extraction_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lee_pkg::point_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lee_pkg::result_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [lee_pkg::THRESH_BITS-1:0]      cfg_wdata
);

  logic                               awaiting_first_r, awaiting_first_nxt;
  logic                               fin_r, fin_nxt;
  logic                               out_valid_r, out_valid_nxt;
  lee_pkg::result_t                   out_data_r, out_data_nxt;
  logic [lee_pkg::THRESH_BITS-1:0]    thresh_r;

  lee_pkg::coord_t top_row_r, top_col_r, bottom_row_r, bottom_col_r;
  lee_pkg::coord_t left_row_r, left_col_r, right_row_r, right_col_r;
  lee_pkg::coord_t top_row_nxt, top_col_nxt, bottom_row_nxt, bottom_col_nxt;
  lee_pkg::coord_t left_row_nxt, left_col_nxt, right_row_nxt, right_col_nxt;

  logic            in_accept;
  logic            out_load;
  logic            res_load;
  lee_pkg::coord_t span;
  logic            col_mode;
  logic            use_left;
  logic            use_right;

  assign out_load  = !out_valid_r || out_ready;
  assign in_ready  = !fin_r || out_load;
  assign in_accept = in_valid && in_ready;
  assign res_load  = fin_r && out_load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    top_row_nxt        = top_row_r;
    top_col_nxt        = top_col_r;
    bottom_row_nxt     = bottom_row_r;
    bottom_col_nxt     = bottom_col_r;
    left_row_nxt       = left_row_r;
    left_col_nxt       = left_col_r;
    right_row_nxt      = right_row_r;
    right_col_nxt      = right_col_r;
    awaiting_first_nxt = awaiting_first_r;
    if (in_accept) begin
      awaiting_first_nxt = in_data.last_point;
      if (awaiting_first_r) begin
        top_row_nxt    = in_data.point_row;
        top_col_nxt    = in_data.point_col;
        bottom_row_nxt = in_data.point_row;
        bottom_col_nxt = in_data.point_col;
        left_row_nxt   = in_data.point_row;
        left_col_nxt   = in_data.point_col;
        right_row_nxt  = in_data.point_row;
        right_col_nxt  = in_data.point_col;
      end else begin
        if (in_data.point_row < top_row_r) begin
          top_row_nxt = in_data.point_row;
          top_col_nxt = in_data.point_col;
        end
        if (in_data.point_row > bottom_row_r) begin
          bottom_row_nxt = in_data.point_row;
          bottom_col_nxt = in_data.point_col;
        end
        if (in_data.point_col < left_col_r) begin
          left_row_nxt = in_data.point_row;
          left_col_nxt = in_data.point_col;
        end
        if (in_data.point_col > right_col_r) begin
          right_row_nxt = in_data.point_row;
          right_col_nxt = in_data.point_col;
        end
      end
    end
  end

  // The span cannot wrap because the bottom row never lies above the top row.
  assign span      = bottom_row_r - top_row_r;
  assign col_mode  = lee_pkg::THRESH_BITS'(span) < thresh_r;
  assign use_left  = col_mode && (left_col_r < top_col_r);
  assign use_right = col_mode && (right_col_r > bottom_col_r);

  always_comb begin
    out_data_nxt                  = out_data_r;
    out_data_nxt.first_end_row    = use_left  ? left_row_r  : top_row_r;
    out_data_nxt.first_end_col    = use_left  ? left_col_r  : top_col_r;
    out_data_nxt.second_end_row   = use_right ? right_row_r : bottom_row_r;
    out_data_nxt.second_end_col   = use_right ? right_col_r : bottom_col_r;
    out_data_nxt.column_mode_used = col_mode;
  end

  always_comb begin
    fin_nxt = fin_r;
    if (in_accept) begin
      fin_nxt = in_data.last_point;
    end else if (res_load) begin
      fin_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_first_r <= 1'b1;
      fin_r            <= 1'b0;
      out_valid_r      <= 1'b0;
      thresh_r         <= lee_pkg::THRESH_RESET;
      top_row_r        <= '0;
      top_col_r        <= '0;
      bottom_row_r     <= '0;
      bottom_col_r     <= '0;
      left_row_r       <= '0;
      left_col_r       <= '0;
      right_row_r      <= '0;
      right_col_r      <= '0;
    end else begin
      awaiting_first_r <= awaiting_first_nxt;
      fin_r            <= fin_nxt;
      out_valid_r      <= out_valid_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      top_row_r        <= top_row_nxt;
      top_col_r        <= top_col_nxt;
      bottom_row_r     <= bottom_row_nxt;
      bottom_col_r     <= bottom_col_nxt;
      left_row_r       <= left_row_nxt;
      left_col_r       <= left_col_nxt;
      right_row_r      <= right_row_nxt;
      right_col_r      <= right_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_IMPLIES(a_fin_opens_run, fin_r, awaiting_first_r,
    "A finished run is pending but the next point would not open a new run.")
  `ASSERT_ALWAYS(a_row_order, top_row_r <= bottom_row_r,
    "The kept top row lies below the kept bottom row.")
  `ASSERT_IMPLIES(a_stall_on_full, fin_r && out_valid_r && !out_ready, !in_ready,
    "A point can be accepted while a finished run has no room in the output register.")
  `ASSERT_NEXT(a_last_sets_fin, in_accept && in_data.last_point, fin_r || out_valid_r,
    "The last point of a run did not lead to a pending or presented result.")

endmodule
